[design/mfhp_pkg.sv]
// mfhp_pkg: shared types and constants for the MQTT fixed header parser.
// Holds word structs, parser state, phase and role codes, flag-nibble table.
// No dependencies.
`timescale 1ns / 1ps

package mfhp_pkg;

	localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
	localparam logic [3:0] TYPE_FIRST_OK = 4'd1;
	localparam logic [3:0] TYPE_LAST_OK  = 4'd14;
	localparam int         LEN_W         = 28;
	localparam logic [2:0] LEN_MAX_BYTES = 3'd4;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_BODY   = 2'd2,
		PH_ERROR  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ROLE_HEADER  = 2'd0,
		ROLE_LENGTH  = 2'd1,
		ROLE_BODY    = 2'd2,
		ROLE_IGNORED = 2'd3
	} role_t;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       restart;
	} in_word_t;

	typedef struct packed {
		logic [1:0]       byte_role;
		logic             error_flag;
		logic [3:0]       packet_type;
		logic             dup_flag;
		logic [1:0]       qos_level;
		logic             retain_flag;
		logic [LEN_W-1:0] body_length;
		logic [7:0]       body_byte;
		logic             packet_done;
	} out_word_t;

	typedef struct packed {
		phase_t           phase;
		logic [3:0]       type_reg;
		logic [3:0]       publish_flags;
		logic [LEN_W-1:0] length_accum;
		logic [2:0]       length_byte_count;
		logic [LEN_W-1:0] bytes_left;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:             PH_HEADER,
		type_reg:          4'd0,
		publish_flags:     4'd0,
		length_accum:      '0,
		length_byte_count: 3'd0,
		bytes_left:        '0
	};

	// required flag nibble for non-PUBLISH types
	function automatic logic [3:0] flag_nibble(input logic [3:0] ptype);
		logic [3:0] r;
		r = (ptype inside {4'd6, 4'd8, 4'd10}) ? 4'd2 : 4'd0;
		return r;
	endfunction

endpackage

[design/mfhp_step.sv]
// mfhp_step: combinational update for one stream word.
// Maps current parser state and the word to next state and result word.
// Depends on mfhp_pkg.
`timescale 1ns / 1ps

module mfhp_step (
	input  mfhp_pkg::state_t    state,
	input  mfhp_pkg::in_word_t  word,
	output mfhp_pkg::state_t    next_state,
	output mfhp_pkg::out_word_t result
);
	import mfhp_pkg::*;

	state_t           cur;
	state_t           nxt;
	logic [3:0]       ptype;
	logic [3:0]       pflags;
	logic             bad_hdr;
	logic [LEN_W-1:0] group;
	logic [LEN_W-1:0] accum_n;
	logic [LEN_W-1:0] left_n;
	role_t            role;
	logic             err;
	logic             done;
	logic [7:0]       body;

	assign ptype  = word.byte_in[7:4];
	assign pflags = word.byte_in[3:0];

	always_comb begin
		case (cur.length_byte_count[1:0])
			2'd0:    group = {21'd0, word.byte_in[6:0]};
			2'd1:    group = {14'd0, word.byte_in[6:0], 7'd0};
			2'd2:    group = {7'd0, word.byte_in[6:0], 14'd0};
			default: group = {word.byte_in[6:0], 21'd0};
		endcase
	end

	assign accum_n = cur.length_accum | group;
	assign left_n  = cur.bytes_left - LEN_W'(1);

	always_comb begin
		if (ptype < TYPE_FIRST_OK || ptype > TYPE_LAST_OK) begin
			bad_hdr = 1'b1;
		end else if (ptype == TYPE_PUBLISH) begin
			bad_hdr = (pflags[2:1] == 2'b11);
		end else begin
			bad_hdr = (pflags != flag_nibble(ptype));
		end
	end

	always_comb begin
		cur  = word.restart ? STATE_RESET : state;
		nxt  = cur;
		role = ROLE_HEADER;
		err  = 1'b0;
		done = 1'b0;
		body = 8'd0;
		case (cur.phase)
			PH_HEADER: begin
				role         = ROLE_HEADER;
				nxt.type_reg = ptype;
				if (bad_hdr) begin
					err                   = 1'b1;
					nxt.phase             = PH_ERROR;
					nxt.publish_flags     = 4'd0;
					nxt.length_accum      = '0;
					nxt.length_byte_count = 3'd0;
					nxt.bytes_left        = '0;
				end else begin
					nxt.publish_flags     = (ptype == TYPE_PUBLISH) ? pflags : 4'd0;
					nxt.phase             = PH_LENGTH;
					nxt.length_accum      = '0;
					nxt.length_byte_count = 3'd0;
				end
			end
			PH_LENGTH: begin
				role = ROLE_LENGTH;
				if (cur.length_byte_count >= LEN_MAX_BYTES) begin
					err                   = 1'b1;
					nxt.phase             = PH_ERROR;
					nxt.publish_flags     = 4'd0;
					nxt.length_accum      = '0;
					nxt.length_byte_count = 3'd0;
					nxt.bytes_left        = '0;
				end else begin
					nxt.length_accum      = accum_n;
					nxt.length_byte_count = cur.length_byte_count + 3'd1;
					if (!word.byte_in[7]) begin
						if (accum_n == '0) begin
							done = 1'b1;
						end else begin
							nxt.bytes_left = accum_n;
							nxt.phase      = PH_BODY;
						end
					end
				end
			end
			PH_BODY: begin
				role           = ROLE_BODY;
				body           = word.byte_in;
				nxt.bytes_left = left_n;
				done           = (left_n == '0);
			end
			default: begin
				role = ROLE_IGNORED;
				err  = 1'b1;
			end
		endcase
	end

	always_comb begin
		result.byte_role   = role;
		result.error_flag  = err;
		result.packet_type = nxt.type_reg;
		result.dup_flag    = nxt.publish_flags[3];
		result.qos_level   = nxt.publish_flags[2:1];
		result.retain_flag = nxt.publish_flags[0];
		result.body_length = (nxt.phase == PH_ERROR) ? '0 : nxt.length_accum;
		result.body_byte   = body;
		result.packet_done = done;
		next_state         = done ? STATE_RESET : nxt;
	end

endmodule

[design/mqtt_fixed_header_parser_core.sv]
// mqtt_fixed_header_parser_core: top level of the MQTT fixed header parser.
// Input register, parser state register, result register; uses mfhp_step.
// Depends on mfhp_pkg.
`timescale 1ns / 1ps
//
//  channel | signals                          | word
//  --------+----------------------------------+----------------------
//  input   | item_valid, item_ready, item     | mfhp_pkg::in_word_t
//  output  | result_valid, result_ready, result | mfhp_pkg::out_word_t
//
// One word per cycle sustained while the output is not stalled; each word is
// loaded into the input register at acceptance and into the result register
// when it advances out of the input register.
// The parser state updates in the same cycle the result register loads.
// Output stall holds the result register; input keeps flowing into the
// input register until both stages are full.
// Reset returns the parser to the header phase and empties both stages.

module mqtt_fixed_header_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mfhp_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output mfhp_pkg::out_word_t result
);
	import mfhp_pkg::*;

	in_word_t  item_s1;
	logic      valid_s1;
	state_t    state_q;
	state_t    state_n;
	out_word_t result_n;
	out_word_t result_q;
	logic      result_valid_q;
	logic      advance;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	mfhp_step u_step (
		.state      (state_q),
		.word       (item_s1),
		.next_state (state_n),
		.result     (result_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= STATE_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_n;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_ERROR |->
			state_q.length_accum == '0 && state_q.publish_flags == 4'd0)
		else $error("error phase with stale packet state");

	a_len_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.length_byte_count <= LEN_MAX_BYTES)
		else $error("length byte count overflow");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled word");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.packet_done |-> !result_q.error_flag)
		else $error("packet completed with error");

endmodule

[bench/tb_mqtt_fixed_header_parser_core.sv]
// tb_mqtt_fixed_header_parser_core: self-checking bench for the MQTT fixed header parser.
// Drives byte words with random gaps and output stalls, predicts each result word in-bench.
// Depends on mfhp_pkg and mqtt_fixed_header_parser_core.
`timescale 1ns / 1ps

module tb_mqtt_fixed_header_parser_core;
	import mfhp_pkg::*;

	localparam logic [3:0] TYPE_PUBREL      = 4'd6;
	localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
	localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;
	localparam logic [3:0] TYPE_RESERVED_LO = 4'd0;
	localparam logic [3:0] TYPE_RESERVED_HI = 4'd15;
	localparam logic [3:0] FLAGS_NONE       = 4'd0;
	localparam logic [3:0] FLAGS_ACKED      = 4'd2;
	localparam logic [1:0] QOS_INVALID      = 2'd3;
	localparam logic [1:0] QOS_MAX          = 2'd2;

	typedef enum int {BAD_TYPE, BAD_FLAGS, BAD_QOS, BAD_LEN_BYTES} bad_kind_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_word_t  item;
	logic      result_valid;
	logic      result_ready;
	out_word_t result;

	state_t    parser;
	out_word_t parsed_q[$];
	int        n_err;
	int        n_live;
	bit        tx_gap_en;
	bit        rx_stall_en;
	bit        need_restart;

	mqtt_fixed_header_parser_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [3:0] header_flags(logic [3:0] t);
		return (t == TYPE_PUBREL || t == TYPE_SUBSCRIBE || t == TYPE_UNSUBSCRIBE) ?
			FLAGS_ACKED : FLAGS_NONE;
	endfunction

	function automatic void parser_to_error();
		parser.phase             = PH_ERROR;
		parser.publish_flags     = '0;
		parser.length_accum      = '0;
		parser.length_byte_count = '0;
		parser.bytes_left        = '0;
	endfunction

	function automatic out_word_t parse_byte(in_word_t w);
		out_word_t r;
		logic [3:0] t;
		logic [3:0] f;
		logic bad;
		r = '0;
		bad = 1'b0;
		t = w.byte_in[7:4];
		f = w.byte_in[3:0];
		if (w.restart)
			parser = STATE_RESET;
		case (parser.phase)
			PH_ERROR: begin
				r.byte_role  = ROLE_IGNORED;
				r.error_flag = 1'b1;
			end
			PH_HEADER: begin
				r.byte_role = ROLE_HEADER;
				parser.type_reg = t;
				if (t < TYPE_FIRST_OK || t > TYPE_LAST_OK)
					bad = 1'b1;
				else if (t == TYPE_PUBLISH)
					bad = (f[2:1] == QOS_INVALID);
				else
					bad = (f != header_flags(t));
				r.error_flag = bad;
				if (bad) begin
					parser_to_error();
				end else begin
					parser.publish_flags     = (t == TYPE_PUBLISH) ? f : FLAGS_NONE;
					parser.phase             = PH_LENGTH;
					parser.length_accum      = '0;
					parser.length_byte_count = '0;
				end
			end
			PH_LENGTH: begin
				r.byte_role = ROLE_LENGTH;
				if (parser.length_byte_count >= LEN_MAX_BYTES) begin
					r.error_flag = 1'b1;
					parser_to_error();
				end else begin
					parser.length_accum = parser.length_accum |
						(LEN_W'(w.byte_in[6:0]) << (7 * parser.length_byte_count));
					parser.length_byte_count = parser.length_byte_count + 3'd1;
					if (!w.byte_in[7]) begin
						if (parser.length_accum == '0) begin
							r.packet_done = 1'b1;
						end else begin
							parser.bytes_left = parser.length_accum;
							parser.phase      = PH_BODY;
						end
					end
				end
			end
			default: begin
				r.byte_role = ROLE_BODY;
				r.body_byte = w.byte_in;
				parser.bytes_left = parser.bytes_left - 1'b1;
				if (parser.bytes_left == '0)
					r.packet_done = 1'b1;
			end
		endcase
		r.packet_type = parser.type_reg;
		r.dup_flag    = parser.publish_flags[3];
		r.qos_level   = parser.publish_flags[2:1];
		r.retain_flag = parser.publish_flags[0];
		r.body_length = (parser.phase == PH_ERROR) ? '0 : parser.length_accum;
		if (r.packet_done)
			parser = STATE_RESET;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			n_err++;
			if (n_err <= 10)
				$display("%0t mismatch %s: expected %0h got %0h", $realtime, name, want_v, got_v);
		end
	endfunction

	always @(posedge clk) begin : check_results
		out_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (parsed_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("%0t unexpected result word %h", $realtime, result);
			end else begin
				want = parsed_q.pop_front();
				check_field("byte_role",   32'(want.byte_role),   32'(result.byte_role));
				check_field("error_flag",  32'(want.error_flag),  32'(result.error_flag));
				check_field("packet_type", 32'(want.packet_type), 32'(result.packet_type));
				check_field("dup_flag",    32'(want.dup_flag),    32'(result.dup_flag));
				check_field("qos_level",   32'(want.qos_level),   32'(result.qos_level));
				check_field("retain_flag", 32'(want.retain_flag), 32'(result.retain_flag));
				check_field("body_length", 32'(want.body_length), 32'(result.body_length));
				check_field("body_byte",   32'(want.body_byte),   32'(result.body_byte));
				check_field("packet_done", 32'(want.packet_done), 32'(result.packet_done));
			end
		end
	end

	// output back-pressure in bursts
	initial begin : sink_ready
		int n;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_stall_en && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 12);
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
		end
	end

	task automatic send_word(logic [7:0] b, logic rs);
		in_word_t  w;
		out_word_t want;
		w.byte_in = b;
		w.restart = rs;
		item       <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		want = parse_byte(w);
		parsed_q.push_back(want);
		if (want.byte_role != ROLE_IGNORED)
			n_live++;
		if (tx_gap_en && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (parsed_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_header(logic [3:0] t, logic [3:0] f);
		send_word({t, f}, need_restart | ($urandom_range(0, 9) == 0));
		need_restart = 1'b0;
	endtask

	task automatic send_packet();
		logic [7:0]  bytes_q[$];
		logic [3:0]  t;
		logic [3:0]  f;
		logic [27:0] rest;
		int unsigned len;
		int unsigned nb;
		int unsigned cut;
		int unsigned pick;
		t = 4'($urandom_range(TYPE_FIRST_OK, TYPE_LAST_OK));
		if (t == TYPE_PUBLISH)
			f = {1'($urandom_range(0, 1)), 2'($urandom_range(0, QOS_MAX)),
				1'($urandom_range(0, 1))};
		else
			f = header_flags(t);
		pick = $urandom_range(0, 99);
		if (pick < 15)
			len = 0;
		else if (pick < 90)
			len = $urandom_range(1, 12);
		else if (pick < 97)
			len = $urandom_range(13, 127);
		else
			len = $urandom_range(128, 300);
		nb = (len < 128) ? 1 : 2;
		if ($urandom_range(0, 5) == 0)
			nb = nb + $urandom_range(0, 4 - nb);
		rest = 28'(len);
		for (int k = 0; k < nb; k++) begin
			bytes_q.push_back({(k < nb - 1), rest[6:0]});
			rest = rest >> 7;
		end
		repeat (len) bytes_q.push_back(8'($urandom_range(0, 255)));
		cut = bytes_q.size();
		if ($urandom_range(0, 11) == 0) begin
			cut = $urandom_range(0, bytes_q.size() - 1);
			need_restart = 1'b1;
		end
		send_header(t, f);
		if (cut < bytes_q.size())
			need_restart = 1'b1;
		for (int k = 0; k < cut; k++)
			send_word(bytes_q[k], 1'b0);
	endtask

	task automatic send_broken_packet();
		bad_kind_t   kind;
		logic [3:0]  t;
		logic [3:0]  f;
		kind = bad_kind_t'($urandom_range(0, 3));
		case (kind)
			BAD_TYPE: begin
				t = $urandom_range(0, 1) ? TYPE_RESERVED_LO : TYPE_RESERVED_HI;
				send_header(t, 4'($urandom_range(0, 15)));
			end
			BAD_FLAGS: begin
				do t = 4'($urandom_range(TYPE_FIRST_OK, TYPE_LAST_OK));
				while (t == TYPE_PUBLISH);
				send_header(t, header_flags(t) ^ 4'($urandom_range(1, 15)));
			end
			BAD_QOS: begin
				f = {1'($urandom_range(0, 1)), QOS_INVALID, 1'($urandom_range(0, 1))};
				send_header(TYPE_PUBLISH, f);
			end
			default: begin
				do t = 4'($urandom_range(TYPE_FIRST_OK, TYPE_LAST_OK));
				while (t == TYPE_PUBLISH);
				send_header(t, header_flags(t));
				repeat (4) send_word({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
				send_word(8'($urandom_range(0, 255)), 1'b0);
			end
		endcase
		repeat ($urandom_range(0, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
		need_restart = 1'b1;
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 3))
			send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
		need_restart = 1'b1;
	endtask

	task automatic test_zero_length();
		send_word(8'hC0, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hE0, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'h00, 1'b0);
	endtask

	task automatic test_publish_flags();
		send_word(8'h3B, 1'b0);
		send_word(8'h02, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h34, 1'b0);
		send_word(8'h00, 1'b0);
	endtask

	task automatic test_header_errors();
		send_word(8'h00, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'hF0, 1'b1);
		send_word(8'h36, 1'b1);
		send_word(8'h60, 1'b1);
		send_word(8'h82, 1'b1);
		send_word(8'h00, 1'b0);
	endtask

	task automatic test_length_limits();
		send_word(8'h10, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h7F, 1'b0);
		// restart in the body of a max-length packet, then too many length bytes
		send_word(8'h20, 1'b1);
		repeat (4) send_word(8'h80, 1'b0);
		send_word(8'h01, 1'b0);
		need_restart = 1'b1;
	endtask

	task automatic test_random_traffic(int count, bit idle);
		int start;
		int pick;
		tx_gap_en   = idle;
		rx_stall_en = idle;
		start = n_live;
		while (n_live - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 80)
				send_packet();
			else if (pick < 92)
				send_broken_packet();
			else
				send_noise();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		parser       = STATE_RESET;
		n_err        = 0;
		n_live       = 0;
		need_restart = 1'b0;
		tx_gap_en    = 1'b1;
		rx_stall_en  = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_length();
		test_publish_flags();
		test_header_errors();
		test_length_limits();
		wait_drained();
		test_random_traffic(200, 1'b1);
		test_random_traffic(120, 1'b0);
		wait_drained();
		test_random_traffic(170, 1'b1);
		test_random_traffic(60, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (n_err == 0)
			$display("tb_mqtt_fixed_header_parser_core: clean");
		else
			$display("tb_mqtt_fixed_header_parser_core: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_mqtt_fixed_header_parser_core: errors");
		$finish;
	end

endmodule
